// ===== rtl/core/ski_pkg.sv =====
// Shared types and constants for the sorted key insert block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ski_pkg;

	localparam int ORDER    = 16;
	localparam int KEY_W    = 32;
	localparam int CAPACITY = ORDER - 1;
	localparam int CNT_W    = $clog2(ORDER);
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Fixed field widths of the item interfaces.
	localparam int IN_KEY_W = 32;
	localparam int STAT_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int HELD_W   = 4;
	localparam int OUT_W    = 16;

	localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_t;

	typedef struct packed {
		logic [HELD_W-1:0] held_count;
		logic [SLOT_W-1:0] slot;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

// ===== rtl/core/ski_cmp.sv =====
// Shared key comparator used by the sequencer for every probe of the store.
// Depends on ski_pkg.
`timescale 1ns / 1ps

module ski_cmp (
	input  logic [ski_pkg::KEY_W-1:0] stored,
	input  logic [ski_pkg::KEY_W-1:0] key,
	output ski_pkg::cmp_t             result
);
	import ski_pkg::*;

	always_comb begin
		result.ge = (stored >= key);
		result.eq = (stored == key);
	end

endmodule

// ===== rtl/core/ski_mem.sv =====
// Key store: one write port and one read port with registered read data.
// Depends on ski_pkg.
`timescale 1ns / 1ps

module ski_mem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [ski_pkg::ADDR_W-1:0] wr_addr,
	input  logic [ski_pkg::KEY_W-1:0]  wr_data,
	input  logic [ski_pkg::ADDR_W-1:0] rd_addr,
	output logic [ski_pkg::KEY_W-1:0]  rd_data
);
	import ski_pkg::*;

	logic [KEY_W-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en && (int'(wr_addr) < CAPACITY)) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (int'(rd_addr) < CAPACITY) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ski_ctrl.sv =====
// Sequencer: scans the store upward for the lower bound; unless the key is a
// duplicate or the store is full, it then shifts larger keys up one slot at a
// time and writes the new key. Depends on ski_pkg, ski_cmp and ski_mem.
`timescale 1ns / 1ps

module ski_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ski_pkg::KEY_W-1:0]  start_key,
	output logic                       idle,
	input  logic                       res_ready,
	output logic                       res_valid,
	output ski_pkg::res_t              res
);
	import ski_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	res_t             res_q;

	logic             wr_en;
	logic [CNT_W-1:0] wr_idx;
	logic [KEY_W-1:0] wr_data;
	logic [CNT_W-1:0] rd_idx;
	logic [KEY_W-1:0] rd_data;
	cmp_t             cmp;
	logic [CNT_W-1:0] idx_inc;
	logic             full;

	assign idx_inc   = idx_q + 1'b1;
	assign full      = (int'(cnt_q) >= CAPACITY);
	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	ski_cmp u_cmp (
		.stored (rd_data),
		.key    (key_q),
		.result (cmp)
	);

	ski_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx[ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_idx[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// Read address runs one step ahead so the data is ready in the next state.
	always_comb begin
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_data = rd_data;
		case (state_q)
			S_IDLE:     rd_idx = '0;
			S_SCAN:     rd_idx = idx_inc;
			S_SHIFT_RD: begin
				rd_idx = idx_q - 1'b1;
				if (idx_q == pos_q) begin
					wr_en   = 1'b1;
					wr_data = key_q;
				end
			end
			S_SHIFT_WR: wr_en = 1'b1;
			default:    rd_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q <= start_key;
						idx_q <= '0;
						pos_q <= '0;
						if (cnt_q == '0) begin
							state_q <= S_SHIFT_RD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cmp.ge && cmp.eq) begin
						res_q.status     <= ST_DUPLICATE;
						res_q.slot       <= SLOT_W'(idx_q);
						res_q.held_count <= HELD_W'(cnt_q);
						state_q          <= S_DONE;
					end else if (cmp.ge || (idx_inc == cnt_q)) begin
						if (full) begin
							res_q.status     <= ST_FULL;
							res_q.slot       <= '0;
							res_q.held_count <= HELD_W'(cnt_q);
							state_q          <= S_DONE;
						end else begin
							pos_q   <= cmp.ge ? idx_q : idx_inc;
							idx_q   <= cnt_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_SHIFT_RD: begin
					if (idx_q == pos_q) begin
						cnt_q            <= cnt_q + 1'b1;
						res_q.status     <= ST_INSERTED;
						res_q.slot       <= SLOT_W'(pos_q);
						res_q.held_count <= HELD_W'(cnt_q + 1'b1);
						state_q          <= S_DONE;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/sorted_key_insert.sv =====
// Top level of the sorted key insert block: input handshake and output register.
// Depends on ski_pkg and ski_ctrl.
`timescale 1ns / 1ps

// Keeps an ascending list of distinct keys, up to ORDER-1 of them, like the
// key array of one B-tree node. Each item on the s_axis side carries a key;
// each item on the m_axis side reports the outcome for one input item, in order.
// The block takes one item at a time: s_axis_tready is high only while the
// sequencer is idle. Duplicates and full-store rejects skip the shift. The
// time taken per item is set by the single read port of the key store,
// which the upward scan reads once per slot and the shift reads once per
// moved key.
// The result sits in an output register; a new item may be accepted while it
// waits. If the receiver stalls, the next result holds in the sequencer
// until the register frees. Reset empties the store (count zero) and clears
// both valid flags; stored key contents are not cleared.

module sorted_key_insert (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [ski_pkg::IN_KEY_W-1:0] s_axis_tdata,  // [31:0] new_key
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [ski_pkg::OUT_W-1:0]   m_axis_tdata   // [1:0] status, [5:2] slot,
	                                                    // [9:6] held_count, rest zero
);
	import ski_pkg::*;

	logic  res_valid;
	logic  res_ready;
	logic  idle;
	res_t  res;
	res_t  out_q;
	logic  out_valid_q;

	assign s_axis_tready = idle;
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_q);

	ski_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid && idle),
		.start_key (KEY_W'(s_axis_tdata)),
		.idle      (idle),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

endmodule

// ===== test/tb_sorted_key_insert.sv =====
// Self-checking testbench for sorted_key_insert: a stream of keys goes in, and each outcome is
// compared with a model of the node's sorted key store kept in the testbench.
// Depends on ski_pkg and the sorted_key_insert RTL.
`timescale 1ns / 1ps

module tb_sorted_key_insert;

	import ski_pkg::*;

	typedef struct {
		logic [IN_KEY_W-1:0] key;
		bit                  wait_drain;
	} key_request_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_KEY_W-1:0] s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;

	key_request_t        key_requests[$];
	res_t                pending_outcomes[$];
	logic [KEY_W-1:0]    node_keys[CAPACITY];
	int                  node_count = 0;
	int                  keys_sent = 0;
	int                  keys_planned = 0;
	int                  mismatch_count = 0;
	bit                  outcomes_drained = 1'b1;
	logic                quiet;

	sorted_key_insert dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// A stretch of items with no idling on either side.
	assign quiet = (keys_sent >= 400) && (keys_sent < 700);

	// Lower-bound search, then duplicate, full or insert with an upward shift.
	function automatic res_t predict_placement(input logic [IN_KEY_W-1:0] new_key);
		res_t             outcome;
		logic [KEY_W-1:0] key;
		int               pos;
		key = new_key[KEY_W-1:0];
		pos = node_count;
		for (int i = node_count - 1; i >= 0; i--) begin
			if (node_keys[i] >= key)
				pos = i;
		end
		if (pos < node_count && node_keys[pos] == key) begin
			outcome.status = ST_DUPLICATE;
			outcome.slot = pos[SLOT_W-1:0];
		end else if (node_count >= CAPACITY) begin
			outcome.status = ST_FULL;
			outcome.slot = '0;
		end else begin
			for (int i = node_count; i > pos; i--)
				node_keys[i] = node_keys[i-1];
			node_keys[pos] = key;
			node_count++;
			outcome.status = ST_INSERTED;
			outcome.slot = pos[SLOT_W-1:0];
		end
		outcome.held_count = node_count[HELD_W-1:0];
		return outcome;
	endfunction

	task automatic report_mismatch(input string what, input res_t want, input logic [OUT_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected status %0d slot %0d held %0d, got tdata %h", $time,
				what, want.status, want.slot, want.held_count, got);
	endtask

	task automatic queue_key(input logic [IN_KEY_W-1:0] key, input bit wait_drain);
		key_request_t req;
		req.key = key;
		req.wait_drain = wait_drain;
		key_requests.push_back(req);
		keys_planned++;
	endtask

	// Sender: a new item is offered only once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (key_requests.size() != 0
				&& !(key_requests[0].wait_drain && (s_axis_tvalid || !outcomes_drained))
				&& (quiet || $urandom_range(0, 99) >= 18)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= key_requests[0].key;
				void'(key_requests.pop_front());
				keys_sent <= keys_sent + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 18);
	end

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_outcomes.push_back(predict_placement(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("result with no item pending", '0, m_axis_tdata);
				end else begin
					want = pending_outcomes.pop_front();
					got = m_axis_tdata[$bits(res_t)-1:0];
					if (got.status != want.status || got.slot != want.slot
						|| got.held_count != want.held_count
						|| m_axis_tdata[OUT_W-1:$bits(res_t)] != '0)
						report_mismatch("wrong result", want, m_axis_tdata);
				end
			end
			outcomes_drained <= (pending_outcomes.size() == 0);
		end
	end

	initial begin
		logic [IN_KEY_W-1:0] fill_keys[11];
		logic [IN_KEY_W-1:0] known_keys[$];
		logic [IN_KEY_W-1:0] key;
		int                  pick;
		fill_keys = '{32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 32'hFFFF_FFFE,
			32'h7FFF_FFFE, 32'h8000_0001, 32'h2000_0000, 32'hA5A5_A5A5,
			32'h5A5A_5A5A, 32'h0000_0002, 32'hE000_0000};

		queue_key(32'h8000_0000, 1'b0);   // empty store: goes to slot 0
		queue_key(32'hFFFF_FFFF, 1'b0);   // above every stored key: appended
		queue_key(32'h0000_0000, 1'b0);   // below every stored key: full shift
		queue_key(32'h8000_0000, 1'b0);
		queue_key(32'h7FFF_FFFF, 1'b0);
		queue_key(32'h0000_0000, 1'b0);
		queue_key(32'hFFFF_FFFF, 1'b0);
		known_keys = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};
		foreach (fill_keys[i]) begin
			queue_key(fill_keys[i], 1'b0);
			known_keys.push_back(fill_keys[i]);
		end
		// The store is full now; duplicates must still win over the full flag.
		queue_key(32'hFFFF_FFFD, 1'b0);
		queue_key(32'h8000_0000, 1'b0);
		queue_key(32'h0000_0000, 1'b0);
		queue_key(32'h1234_5678, 1'b0);

		for (int n = 0; n < 1600; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				key = known_keys[$urandom_range(0, known_keys.size() - 1)];
			else if (pick < 60)
				key = known_keys[$urandom_range(0, known_keys.size() - 1)]
					+ (($urandom_range(0, 1) != 0) ? 32'd1 : 32'hFFFF_FFFF);
			else if (pick < 70)
				key = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
			else
				key = $urandom();
			queue_key(key, (n == 800) || (n == 1300));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (keys_sent != keys_planned || s_axis_tvalid || pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
